// ===== sv/smv_pkg.sv =====
// ----------------------------------------------------------------------------
// smv_pkg: shared types and constants for the sparse matrix-vector multiplier
// Holds the transaction structs, action codes, register indexes and the
// fixed widths of the fixed-point datapath.
// ----------------------------------------------------------------------------
package smv_pkg;

    // Field widths of the transactions.
    localparam int ACTION_W  = 3;
    localparam int INDEX_W   = 6;
    localparam int VAL_FW    = 32;
    localparam int DIM_FW    = 7;
    localparam int CFG_IDX_W = 2;

    // Accumulator width and number of fraction bits in Q16.16.
    localparam int ACC_W     = 48;
    localparam int FRAC_BITS = 16;

    // Actions.
    localparam logic [ACTION_W-1:0] ACT_ENTRY = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SRC   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DST   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

    // Bits of the mode register.
    localparam int MODE_ADD_BIT   = 0;
    localparam int MODE_TRANS_BIT = 1;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [INDEX_W-1:0]       row_index;
        logic [INDEX_W-1:0]       col_index;
        logic signed [VAL_FW-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0]       out_index;
        logic signed [VAL_FW-1:0] out_value;
        logic                     last;
        logic                     overflow;
    } t_out_item;

endpackage

// ===== sv/smv_entry_mem.sv =====
// ----------------------------------------------------------------------------
// smv_entry_mem: sparse matrix entry store
// One write port and one registered read port over (row, column, value)
// entries. The read data holds while no read is requested.
// ----------------------------------------------------------------------------
module smv_entry_mem
    import smv_pkg::*;
#(
    parameter int ENTRIES     = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 10
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [INDEX_W-1:0]            i_wr_row,
    input  logic [INDEX_W-1:0]            i_wr_col,
    input  logic signed [VALUE_WIDTH-1:0] i_wr_value,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [INDEX_W-1:0]            o_rd_row,
    output logic [INDEX_W-1:0]            o_rd_col,
    output logic signed [VALUE_WIDTH-1:0] o_rd_value
);

    localparam int EW = 2 * INDEX_W + VALUE_WIDTH;

    logic [EW-1:0] r_mem [ENTRIES];
    logic [EW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_row, i_wr_col, i_wr_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row   = r_q[EW-1 -: INDEX_W];
    assign o_rd_col   = r_q[VALUE_WIDTH +: INDEX_W];
    assign o_rd_value = signed'(r_q[VALUE_WIDTH-1:0]);

endmodule

// ===== sv/smv_mac.sv =====
// ----------------------------------------------------------------------------
// smv_mac: shared multiply-accumulate unit
// Registers the full product of two fixed-point values, then adds the
// product, floored to Q32.16, to an accumulator value modulo 2^48.
// ----------------------------------------------------------------------------
module smv_mac
    import smv_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    input  logic signed [ACC_W-1:0]       i_acc,
    output logic signed [ACC_W-1:0]       o_sum
);

    localparam int PW = 2 * VALUE_WIDTH;

    logic signed [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_a) * PW'(i_b);
        end
    end

    // An arithmetic shift rounds toward minus infinity, as required.
    assign o_sum = i_acc + ACC_W'(r_prod >>> FRAC_BITS);

endmodule

// ===== sv/sparse_matrix_vector_multiply.sv =====
// One multiplier and the accumulator memory are shared. Entry write: SRCH, SCMP per stored entry
// searched, then APND if none matches; vector writes and clear finish in idle. Start: INIT and
// INIT2 per element of set-up, WRD, WCHK, WMUL and WACC per stored entry in range (WRD and WCHK
// if skipped), then ERD and EOUT per result; len is num_rows, or num_cols when transposed.
// Results are strobed for one cycle each; the receiver cannot stall them. Reset clears control,
// the entry count, overflow, mode and destination valid bits, and sets num_rows, num_cols to 64.
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply: sparse matrix times vector, Q16.16
// Keeps a list of matrix entries, a source vector and a destination vector,
// and on start walks the entry list through one multiply-accumulate unit.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply
    import smv_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_DIM     = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    output logic                 o_strobe,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_FW-1:0]    i_cfg_data
);

    localparam int ENT_AW = $clog2(MAX_ENTRIES);
    localparam int ENT_CW = $clog2(MAX_ENTRIES + 1);
    localparam int DIM_AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [DIM_FW-1:0] DIM_LIM = DIM_FW'(MAX_DIM);
    localparam logic [ENT_CW-1:0] ENT_LIM = ENT_CW'(MAX_ENTRIES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_APND  = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;
    localparam logic [3:0] S_INIT2 = 4'd5;
    localparam logic [3:0] S_WRD   = 4'd6;
    localparam logic [3:0] S_WCHK  = 4'd7;
    localparam logic [3:0] S_WMUL  = 4'd8;
    localparam logic [3:0] S_WACC  = 4'd9;
    localparam logic [3:0] S_ERD   = 4'd10;
    localparam logic [3:0] S_EOUT  = 4'd11;

    function automatic logic [DIM_FW-1:0] f_clamp(input logic [DIM_FW-1:0] d);
        logic [DIM_FW-1:0] res;
        res = d;
        if (d == '0) begin
            res = DIM_FW'(1);
        end else if (d > DIM_LIM) begin
            res = DIM_LIM;
        end
        return res;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] f_sat(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-VALUE_WIDTH:0] top;
        logic signed [VALUE_WIDTH-1:0] res;
        top = a[ACC_W-1:VALUE_WIDTH-1];
        if ((&top) || !(|top)) begin
            res = a[VALUE_WIDTH-1:0];
        end else if (a[ACC_W-1]) begin
            res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // Control and configuration registers.
    logic [3:0]        r_state, n_state;
    logic [ENT_CW-1:0] r_k, n_k;
    logic [ENT_CW-1:0] r_count, n_count;
    logic              r_dropped, n_dropped;
    logic [DIM_FW-1:0] r_i, n_i;
    logic [DIM_AW-1:0] r_aidx, n_aidx;
    logic [DIM_FW-1:0] r_len, r_rows, r_cols;
    logic              r_add, r_trans;
    logic [DIM_FW-1:0] r_num_rows, r_num_cols;
    logic [1:0]        r_mode;
    logic [MAX_DIM-1:0] r_dvalid;
    t_in_item          r_item;
    logic              r_strobe;
    t_out_item         r_result;

    // Vector and accumulator memories.
    logic signed [VALUE_WIDTH-1:0] r_src_mem [MAX_DIM];
    logic signed [VALUE_WIDTH-1:0] r_dst_mem [MAX_DIM];
    logic signed [ACC_W-1:0]       r_acc_mem [MAX_DIM];
    logic signed [VALUE_WIDTH-1:0] r_src_q, r_dst_q;
    logic                          r_dvq;
    logic signed [ACC_W-1:0]       r_acc_q;

    logic                          accept;
    logic [DIM_FW-1:0]             rows_c, cols_c;
    logic                          in_dim;
    logic [DIM_FW-1:0]             i_next;
    logic [ENT_CW-1:0]             k_next;

    logic                          ent_we, ent_re;
    logic [ENT_AW-1:0]             ent_wa;
    logic [INDEX_W-1:0]            ent_row, ent_col;
    logic signed [VALUE_WIDTH-1:0] ent_val;
    logic                          src_we, src_re, dst_we, dst_re, acc_we, acc_re;
    logic [DIM_AW-1:0]             src_ra, dst_wa, acc_wa, acc_ra;
    logic signed [VALUE_WIDTH-1:0] dst_wd, sat_val;
    logic signed [ACC_W-1:0]       acc_wd, mac_sum;
    logic                          mac_en, emit;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign rows_c = f_clamp(r_num_rows);
    assign cols_c = f_clamp(r_num_cols);
    assign in_dim = ({1'b0, i_item.row_index} < DIM_LIM);
    assign i_next = DIM_FW'(r_i + DIM_FW'(1));
    assign k_next = ENT_CW'(r_k + ENT_CW'(1));
    assign sat_val = f_sat(r_acc_q);

    smv_entry_mem #(
        .ENTRIES     (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (ENT_AW)
    ) u_entry_mem (
        .i_clk      (i_clk),
        .i_wr_en    (ent_we),
        .i_wr_addr  (ent_wa),
        .i_wr_row   (r_item.row_index),
        .i_wr_col   (r_item.col_index),
        .i_wr_value (r_item.value[VALUE_WIDTH-1:0]),
        .i_rd_en    (ent_re),
        .i_rd_addr  (r_k[ENT_AW-1:0]),
        .o_rd_row   (ent_row),
        .o_rd_col   (ent_col),
        .o_rd_value (ent_val)
    );

    smv_mac #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mac (
        .i_clk (i_clk),
        .i_en  (mac_en),
        .i_a   (ent_val),
        .i_b   (r_src_q),
        .i_acc (r_acc_q),
        .o_sum (mac_sum)
    );

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_i       = r_i;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_aidx    = r_aidx;
        ent_we    = 1'b0;
        ent_wa    = r_k[ENT_AW-1:0];
        ent_re    = 1'b0;
        src_we    = 1'b0;
        src_re    = 1'b0;
        src_ra    = r_trans ? ent_row[DIM_AW-1:0] : ent_col[DIM_AW-1:0];
        dst_we    = 1'b0;
        dst_wa    = r_i[DIM_AW-1:0];
        dst_wd    = sat_val;
        dst_re    = 1'b0;
        acc_we    = 1'b0;
        acc_wa    = r_i[DIM_AW-1:0];
        acc_wd    = mac_sum;
        acc_re    = 1'b0;
        acc_ra    = r_trans ? ent_col[DIM_AW-1:0] : ent_row[DIM_AW-1:0];
        mac_en    = 1'b0;
        emit      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.action)
                        ACT_ENTRY: begin
                            n_k     = '0;
                            n_state = (r_count == '0) ? S_APND : S_SRCH;
                        end
                        ACT_SRC: begin
                            src_we = in_dim;
                        end
                        ACT_DST: begin
                            dst_we = in_dim;
                            dst_wa = i_item.row_index[DIM_AW-1:0];
                            dst_wd = i_item.value[VALUE_WIDTH-1:0];
                        end
                        ACT_START: begin
                            n_i     = '0;
                            n_state = S_INIT;
                        end
                        ACT_CLEAR: begin
                            n_count   = '0;
                            n_dropped = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                ent_re  = 1'b1;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (ent_row == r_item.row_index && ent_col == r_item.col_index) begin
                    ent_we  = 1'b1;
                    n_state = S_IDLE;
                end else if (k_next == r_count) begin
                    n_state = S_APND;
                end else begin
                    n_k     = k_next;
                    n_state = S_SRCH;
                end
            end
            S_APND: begin
                if (r_count < ENT_LIM) begin
                    ent_we  = 1'b1;
                    ent_wa  = r_count[ENT_AW-1:0];
                    n_count = ENT_CW'(r_count + ENT_CW'(1));
                end else begin
                    n_dropped = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_INIT: begin
                dst_re  = 1'b1;
                n_state = S_INIT2;
            end
            S_INIT2: begin
                acc_we = 1'b1;
                acc_wd = (r_add && r_dvq) ? ACC_W'(r_dst_q) : '0;
                if (i_next == r_len) begin
                    n_k     = '0;
                    n_i     = '0;
                    n_state = (r_count == '0) ? S_ERD : S_WRD;
                end else begin
                    n_i     = i_next;
                    n_state = S_INIT;
                end
            end
            S_WRD: begin
                ent_re  = 1'b1;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (({1'b0, ent_row} < r_rows) && ({1'b0, ent_col} < r_cols)) begin
                    src_re  = 1'b1;
                    acc_re  = 1'b1;
                    n_aidx  = acc_ra;
                    n_state = S_WMUL;
                end else if (k_next == r_count) begin
                    n_state = S_ERD;
                end else begin
                    n_k     = k_next;
                    n_state = S_WRD;
                end
            end
            S_WMUL: begin
                mac_en  = 1'b1;
                n_state = S_WACC;
            end
            S_WACC: begin
                acc_we = 1'b1;
                acc_wa = r_aidx;
                if (k_next == r_count) begin
                    n_state = S_ERD;
                end else begin
                    n_k     = k_next;
                    n_state = S_WRD;
                end
            end
            S_ERD: begin
                acc_re  = 1'b1;
                acc_ra  = r_i[DIM_AW-1:0];
                n_state = S_EOUT;
            end
            S_EOUT: begin
                emit   = 1'b1;
                dst_we = 1'b1;
                n_i    = i_next;
                if (i_next == r_len) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_num_rows <= DIM_FW'(64);
            r_num_cols <= DIM_FW'(64);
            r_mode     <= '0;
            r_dvalid   <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_strobe  <= emit;
            if (dst_we) begin
                r_dvalid[dst_wa] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                    CFG_MODE:     r_mode     <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_i    <= n_i;
        r_aidx <= n_aidx;
        if (accept) begin
            r_item  <= i_item;
            r_rows  <= rows_c;
            r_cols  <= cols_c;
            r_add   <= r_mode[MODE_ADD_BIT];
            r_trans <= r_mode[MODE_TRANS_BIT];
            r_len   <= r_mode[MODE_TRANS_BIT] ? cols_c : rows_c;
        end
        if (emit) begin
            r_result.out_index <= r_i[INDEX_W-1:0];
            r_result.out_value <= VAL_FW'(sat_val);
            r_result.last      <= (i_next == r_len);
            r_result.overflow  <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            r_src_mem[i_item.row_index[DIM_AW-1:0]] <= i_item.value[VALUE_WIDTH-1:0];
        end
        if (src_re) begin
            r_src_q <= r_src_mem[src_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dst_we) begin
            r_dst_mem[dst_wa] <= dst_wd;
        end
        if (dst_re) begin
            r_dst_q <= r_dst_mem[r_i[DIM_AW-1:0]];
            r_dvq   <= r_dvalid[r_i[DIM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc_mem[acc_wa] <= acc_wd;
        end
        if (acc_re) begin
            r_acc_q <= r_acc_mem[acc_ra];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The entry count never passes the capacity of the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ENT_LIM)
        else $error("entry count beyond capacity");

    // Overflow is only raised by an append into a full store.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_dropped) |-> ($past(r_count) == ENT_LIM && $past(r_state) == S_APND))
        else $error("overflow raised without a full store");

    // Result strobes are never back to back.
    a_emit_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    // While more results of a run are due, the sequencer stays busy.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("run ended before its last result");

    // A start transaction always launches the sequencer.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.action == ACT_START) |=> busy)
        else $error("start transaction not taken up");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sparse_matrix_vector_multiply
// Issues entry, vector, start, clear and unused action commands from a queue and keeps its
// own copy of the matrix store, vectors and registers. Every strobed result
// is compared against the expected destination elements, in order.
// ----------------------------------------------------------------------------
module tb;
    import smv_pkg::*;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_DIM     = 64;
    localparam int VALUE_WIDTH = 32;

    // Long enough for a start over a full store, or an entry search.
    localparam int SETTLE_CYCLES = 4 * MAX_ENTRIES + 4 * MAX_DIM + 16;
    localparam int TIMEOUT_NS    = 20_000_000;
    localparam int PHASE_ITEMS   = 30;
    localparam int RANDOM_PHASES = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam logic [ACTION_W-1:0]  ACT_TOP_CODE  = '1;
    localparam logic [1:0]           MODE_MUL      = 2'd0;
    localparam logic [1:0]           MODE_MUL_ADD  = 2'd1;
    localparam logic [1:0]           MODE_TMUL     = 2'd2;
    localparam logic [1:0]           MODE_TMUL_ADD = 2'd3;

    localparam logic signed [VAL_FW-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_FW-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [VAL_FW-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [VAL_FW-1:0] Q_LSB     = 32'sh0000_0001;
    localparam logic signed [VAL_FW-1:0] Q_NEG_LSB = 32'shFFFF_FFFF;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_in_item             i_item      = '0;
    logic                 o_strobe;
    t_out_item            o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_FW-1:0]    i_cfg_data  = '0;

    // Mirror of the block's state.
    logic [INDEX_W-1:0]       mat_row [MAX_ENTRIES];
    logic [INDEX_W-1:0]       mat_col [MAX_ENTRIES];
    logic signed [VAL_FW-1:0] mat_val [MAX_ENTRIES];
    int                       mat_count   = 0;
    logic                     mat_dropped = 1'b0;
    logic signed [VAL_FW-1:0] src_vec [MAX_DIM];
    logic signed [VAL_FW-1:0] dst_vec [MAX_DIM];
    logic [DIM_FW-1:0]        rows_reg = 7'd64;
    logic [DIM_FW-1:0]        cols_reg = 7'd64;
    logic [1:0]               mode_reg = MODE_MUL;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    bit        quiet_tail     = 1'b0;
    bit        failed         = 1'b0;
    int        idle_left      = 0;

    sparse_matrix_vector_multiply #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .MAX_DIM    (MAX_DIM),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int used_dim(logic [DIM_FW-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    function automatic t_in_item make_item(logic [ACTION_W-1:0] act, int row, int col,
                                           logic signed [VAL_FW-1:0] val);
        t_in_item it;
        it.action    = act;
        it.row_index = INDEX_W'(row);
        it.col_index = INDEX_W'(col);
        it.value     = val;
        return it;
    endfunction

    // Small Q16.16 values keep sums in range; extremes, zero and random words are mixed in.
    function automatic logic signed [VAL_FW-1:0] rand_value();
        int s;
        s = $urandom_range(0, 1 << 19);
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_NEG_LSB;
            4, 5: return $urandom;
            default: return VAL_FW'(s - (1 << 18));
        endcase
    endfunction

    function automatic t_in_item rand_item();
        int pick;
        int row;
        int col;
        logic [ACTION_W-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 42) act = ACT_ENTRY;
        else if (pick < 56) act = ACT_SRC;
        else if (pick < 68) act = ACT_DST;
        else if (pick < 84) act = ACT_START;
        else if (pick < 90) act = ACT_CLEAR;
        else act = ACTION_W'($urandom_range(ACT_CLEAR + 1, ACT_TOP_CODE));
        // Most positions fall inside the current shape; the rest may be skipped.
        if ($urandom_range(0, 3) != 0) begin
            row = $urandom_range(0, used_dim(rows_reg) - 1);
            col = $urandom_range(0, used_dim(cols_reg) - 1);
        end else begin
            row = $urandom_range(0, MAX_DIM - 1);
            col = $urandom_range(0, MAX_DIM - 1);
        end
        return make_item(act, row, col, rand_value());
    endfunction

    // Updates the mirror for one accepted transaction and queues any results.
    task automatic apply_item(input t_in_item it);
        int                       rows;
        int                       cols;
        int                       len;
        int                       k;
        int                       hit;
        int                       ri;
        int                       ci;
        bit                       trans;
        logic [ACC_W-1:0]         acc [MAX_DIM];
        logic signed [ACC_W-1:0]  sum;
        longint                   prod;
        longint                   wide;
        t_out_item                res;
        case (it.action)
            ACT_ENTRY: begin
                hit = -1;
                for (k = 0; k < mat_count; k++)
                    if (mat_row[k] == it.row_index && mat_col[k] == it.col_index)
                        hit = k;
                if (hit >= 0) begin
                    mat_val[hit] = it.value;
                end else if (mat_count < MAX_ENTRIES) begin
                    mat_row[mat_count] = it.row_index;
                    mat_col[mat_count] = it.col_index;
                    mat_val[mat_count] = it.value;
                    mat_count++;
                end else begin
                    mat_dropped = 1'b1;
                end
            end
            ACT_SRC: src_vec[it.row_index] = it.value;
            ACT_DST: dst_vec[it.row_index] = it.value;
            ACT_START: begin
                rows  = used_dim(rows_reg);
                cols  = used_dim(cols_reg);
                trans = mode_reg[MODE_TRANS_BIT];
                len   = trans ? cols : rows;
                for (k = 0; k < MAX_DIM; k++)
                    acc[k] = (mode_reg[MODE_ADD_BIT] && k < len)
                           ? {{(ACC_W - VAL_FW){dst_vec[k][VAL_FW-1]}}, dst_vec[k]} : '0;
                for (k = 0; k < mat_count; k++) begin
                    ri = mat_row[k];
                    ci = mat_col[k];
                    if (ri < rows && ci < cols) begin
                        prod = longint'(mat_val[k]) * longint'(src_vec[trans ? ri : ci]);
                        // An arithmetic shift rounds towards minus infinity.
                        prod = prod >>> FRAC_BITS;
                        if (trans) acc[ci] = acc[ci] + prod[ACC_W-1:0];
                        else acc[ri] = acc[ri] + prod[ACC_W-1:0];
                    end
                end
                for (k = 0; k < len; k++) begin
                    sum  = acc[k];
                    wide = sum;
                    if (wide > Q_MAX) wide = Q_MAX;
                    else if (wide < Q_MIN) wide = Q_MIN;
                    dst_vec[k]    = wide[VAL_FW-1:0];
                    res.out_index = k[INDEX_W-1:0];
                    res.out_value = dst_vec[k];
                    res.last      = (k == len - 1);
                    res.overflow  = mat_dropped;
                    expected_results.push_back(res);
                end
            end
            ACT_CLEAR: begin
                mat_count   = 0;
                mat_dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [VAL_FW-1:0] want, got);
        failed = 1'b1;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    // Register writes on consecutive edges, including the unused index.
    task automatic set_shape(input logic [DIM_FW-1:0] rows_data, cols_data,
                             input logic [1:0] mode_code);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [DIM_FW-1:0]    data [4];
        idx  = '{CFG_NUM_ROWS, CFG_NUM_COLS, CFG_MODE, CFG_SPARE};
        data = '{rows_data, cols_data, {(DIM_FW - 2)'($urandom), mode_code},
                 DIM_FW'($urandom)};
        for (int n = 0; n < 4; n++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[n];
            i_cfg_data  <= data[n];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rows_reg = rows_data;
        cols_reg = cols_data;
        mode_reg = mode_code;
    endtask

    // Polled on the falling edge so that the driver's updates have settled.
    task automatic wait_settled();
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver: presents queued commands, with random bursts of idle cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy)
                apply_item(i_item);
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    start     <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (pending_items.size() != 0) begin
                    start  <= 1'b1;
                    i_item <= pending_items.pop_front();
                    if (!quiet_tail && $urandom_range(0, 3) == 0)
                        idle_left <= $urandom_range(1, 6);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", '0, o_result.out_value);
            end else begin
                want = expected_results.pop_front();
                if (o_result.out_index !== want.out_index)
                    report("out_index", want.out_index, o_result.out_index);
                if (o_result.out_value !== want.out_value)
                    report("out_value", want.out_value, o_result.out_value);
                if (o_result.last !== want.last)
                    report("last", want.last, o_result.last);
                if (o_result.overflow !== want.overflow)
                    report("overflow", want.overflow, o_result.overflow);
            end
        end
    end

    initial begin
        int k;
        int phase;
        logic signed [VAL_FW-1:0] v;
        for (k = 0; k < MAX_DIM; k++) begin
            src_vec[k] = '0;
            dst_vec[k] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every source element is written before any start reads it.
        for (k = 0; k < MAX_DIM; k++) begin
            if (k < 4) v = Q_MAX;
            else if (k < 8) v = Q_MIN;
            else if (k == 8) v = Q_NEG_LSB;
            else if (k == 9) v = Q_ONE;
            else v = rand_value();
            pending_items.push_back(make_item(ACT_SRC, k, $urandom_range(0, 63), v));
        end

        // Row 0 saturates high, row 1 wraps the 48-bit sum, row 2 saturates low,
        // rows 3 and 5 check rounding of negative products.
        pending_items.push_back(make_item(ACT_ENTRY, 0, 0, Q_MAX));
        pending_items.push_back(make_item(ACT_ENTRY, 0, 1, Q_MAX));
        for (k = 0; k < 4; k++)
            pending_items.push_back(make_item(ACT_ENTRY, 1, k, Q_MAX));
        pending_items.push_back(make_item(ACT_ENTRY, 2, 0, Q_MIN));
        pending_items.push_back(make_item(ACT_ENTRY, 3, 8, Q_LSB));
        pending_items.push_back(make_item(ACT_ENTRY, 5, 9, Q_NEG_LSB));
        pending_items.push_back(make_item(ACT_ENTRY, 63, 63, rand_value()));
        pending_items.push_back(make_item(ACT_START, 0, 0, '0));
        // Rewriting a stored position replaces its value.
        pending_items.push_back(make_item(ACT_ENTRY, 1, 3, Q_ONE));
        pending_items.push_back(make_item(ACT_DST, 62, 0, Q_MAX));
        pending_items.push_back(make_item(ACT_DST, 63, 63, Q_MIN));
        for (k = ACT_CLEAR + 1; k <= ACT_TOP_CODE; k++)
            pending_items.push_back(make_item(ACTION_W'(k), $urandom_range(0, 63),
                                              $urandom_range(0, 63), $urandom));
        pending_items.push_back(make_item(ACT_START, 63, 63, Q_MAX));
        pending_items.push_back(make_item(ACT_CLEAR, 0, 0, '0));
        pending_items.push_back(make_item(ACT_START, 0, 0, '0));
        pending_items.push_back(make_item(ACT_ENTRY, 63, 0, Q_MIN));
        pending_items.push_back(make_item(ACT_SRC, 0, 0, rand_value()));
        pending_items.push_back(make_item(ACT_START, 0, 0, '0));
        wait_settled();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_shape(7'd64, 7'd64, MODE_MUL_ADD);
                1: set_shape(7'd1, 7'd1, MODE_TMUL);
                2: set_shape(7'd0, 7'd127, MODE_TMUL_ADD);
                3: set_shape(7'd127, 7'd0, MODE_MUL);
                default: set_shape(DIM_FW'($urandom_range(1, MAX_DIM)),
                                   DIM_FW'($urandom_range(1, MAX_DIM)),
                                   2'($urandom_range(MODE_MUL, MODE_TMUL_ADD)));
            endcase
            if (phase == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                pending_items.push_back(rand_item());
            wait_settled();
        end

        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
